>>> rtl/sparse_matrix_store_unit_defines.svh
// ----------------------------------------------------------------------------
// Sparse matrix store unit assertion macros
// Concurrent property helpers, compiled out when NO_ASSERTIONS is set.
// ----------------------------------------------------------------------------
`ifndef SPARSE_MATRIX_STORE_UNIT_DEFINES_SVH
`define SPARSE_MATRIX_STORE_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define SMSU_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("smsu assertion failed");
`define SMSU_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("smsu assertion failed");
`else
`define SMSU_ASSERT_SAME(label, clk, rst, ante, cons)
`define SMSU_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

>>> rtl/smsu_pkg.sv
// ----------------------------------------------------------------------------
// Sparse matrix store unit package
// Command, status and register codes, and controller/datapath handshake types.
// ----------------------------------------------------------------------------
package smsu_pkg;

  localparam int unsigned CMD_BITS       = 2;
  localparam int unsigned STATUS_BITS    = 2;
  localparam int unsigned CFG_INDEX_BITS = 2;

  typedef logic [CMD_BITS-1:0]       cmd_code_t;
  typedef logic [STATUS_BITS-1:0]    status_t;
  typedef logic [CFG_INDEX_BITS-1:0] cfg_index_t;

  localparam cmd_code_t CMD_GET   = 2'd0;
  localparam cmd_code_t CMD_SET   = 2'd1;
  localparam cmd_code_t CMD_CLEAR = 2'd2;

  localparam status_t ST_OK   = 2'd0;
  localparam status_t ST_OOB  = 2'd1;
  localparam status_t ST_FULL = 2'd2;

  localparam cfg_index_t REG_ROW_COUNT     = 2'd0;
  localparam cfg_index_t REG_COL_COUNT     = 2'd1;
  localparam cfg_index_t REG_DEFAULT_VALUE = 2'd2;

  typedef struct packed {
    logic load;
    logic scan;
    logic finish;
  } smsu_cmd_t;

  typedef struct packed {
    logic scan_done;
    logic out_free;
  } smsu_stat_t;

endpackage

>>> rtl/smsu_cfg_if.sv
// ----------------------------------------------------------------------------
// Sparse matrix store unit configuration channel
// Register write transfer: index and data under valid/ready.
// ----------------------------------------------------------------------------
interface smsu_cfg_if import smsu_pkg::*; #(
  parameter int unsigned DATA_BITS = 32
);
  logic                 valid;
  logic                 ready;
  cfg_index_t           index;
  logic [DATA_BITS-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

>>> rtl/smsu_req_if.sv
// ----------------------------------------------------------------------------
// Sparse matrix store unit request channel
// One command transfer: command, row, column and value under valid/ready.
// ----------------------------------------------------------------------------
interface smsu_req_if import smsu_pkg::*; #(
  parameter int unsigned INDEX_BITS = 16,
  parameter int unsigned VALUE_BITS = 32
);
  logic                  valid;
  logic                  ready;
  cmd_code_t             command;
  logic [INDEX_BITS-1:0] row;
  logic [INDEX_BITS-1:0] col;
  logic [VALUE_BITS-1:0] value;

  modport source (output valid, output command, output row, output col, output value,
                  input ready);
  modport sink   (input valid, input command, input row, input col, input value,
                  output ready);
endinterface

>>> rtl/smsu_rsp_if.sv
// ----------------------------------------------------------------------------
// Sparse matrix store unit response channel
// One result transfer: read value and status under valid/ready.
// ----------------------------------------------------------------------------
interface smsu_rsp_if import smsu_pkg::*; #(
  parameter int unsigned VALUE_BITS = 32
);
  logic                  valid;
  logic                  ready;
  logic [VALUE_BITS-1:0] read_value;
  status_t               status;

  modport source (output valid, output read_value, output status, input ready);
  modport sink   (input valid, input read_value, input status, output ready);
endinterface

>>> rtl/smsu_ram.sv
// ----------------------------------------------------------------------------
// Sparse matrix store unit RAM
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module smsu_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/smsu_ctrl.sv
// ----------------------------------------------------------------------------
// Sparse matrix store unit controller
// Sequences accept, slot scan and write-back/result for each command.
// ----------------------------------------------------------------------------
module smsu_ctrl import smsu_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       req_valid,
  output logic       req_ready,
  input  smsu_stat_t stat,
  output smsu_cmd_t  cmd
);

  typedef enum logic [1:0] {
    IDLE,
    SCAN,
    FINISH
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    state_next = state;
    unique case (state)
      IDLE: begin
        if (req_valid) begin
          state_next = SCAN;
        end
      end
      SCAN: begin
        if (stat.scan_done) begin
          state_next = FINISH;
        end
      end
      FINISH: begin
        if (stat.out_free) begin
          state_next = IDLE;
        end
      end
      default: begin
        state_next = IDLE;
      end
    endcase
  end

  assign req_ready  = (state == IDLE);
  assign cmd.load   = (state == IDLE) && req_valid;
  assign cmd.scan   = (state == SCAN);
  assign cmd.finish = (state == FINISH) && stat.out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

>>> rtl/smsu_datapath.sv
// ----------------------------------------------------------------------------
// Sparse matrix store unit datapath
// Slot RAM, fill mark, scan match/free tracking, config and result registers.
// ----------------------------------------------------------------------------
module smsu_datapath import smsu_pkg::*; #(
  parameter int unsigned SLOT_COUNT = 256,
  parameter int unsigned INDEX_BITS = 16,
  parameter int unsigned VALUE_BITS = 32,
  parameter int unsigned CFG_BITS   = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  smsu_cmd_t             cmd,
  output smsu_stat_t            stat,
  input  logic                  cfg_write,
  input  cfg_index_t            cfg_index,
  input  logic [CFG_BITS-1:0]   cfg_data,
  input  cmd_code_t             req_command,
  input  logic [INDEX_BITS-1:0] req_row,
  input  logic [INDEX_BITS-1:0] req_col,
  input  logic [VALUE_BITS-1:0] req_value,
  input  logic                  rsp_ready,
  output logic                  rsp_valid,
  output logic [VALUE_BITS-1:0] rsp_read_value,
  output status_t               rsp_status
);

  localparam int unsigned ADDR_BITS  = $clog2(SLOT_COUNT);
  localparam int unsigned CNT_BITS   = $clog2(SLOT_COUNT + 1);
  localparam int unsigned COUNT_BITS = INDEX_BITS + 1;
  localparam int unsigned ENTRY_BITS = 1 + 2 * INDEX_BITS + VALUE_BITS;
  localparam logic [CNT_BITS-1:0]   SLOT_LIMIT = CNT_BITS'(SLOT_COUNT);
  localparam logic [COUNT_BITS-1:0] SIZE_RESET = COUNT_BITS'(1) << INDEX_BITS;

  logic [COUNT_BITS-1:0] row_count;
  logic [COUNT_BITS-1:0] col_count;
  logic [VALUE_BITS-1:0] default_value;

  cmd_code_t             cmd_q;
  logic [INDEX_BITS-1:0] row_q;
  logic [INDEX_BITS-1:0] col_q;
  logic [VALUE_BITS-1:0] value_q;

  logic [CNT_BITS-1:0]   hwm;
  logic [CNT_BITS-1:0]   issue_idx;
  logic                  pend;
  logic [ADDR_BITS-1:0]  pend_addr;
  logic                  hit;
  logic [ADDR_BITS-1:0]  hit_addr;
  logic [VALUE_BITS-1:0] hit_value;
  logic                  free_found;
  logic [ADDR_BITS-1:0]  free_addr;

  logic                  ram_we;
  logic [ADDR_BITS-1:0]  ram_waddr;
  logic [ENTRY_BITS-1:0] ram_wdata;
  logic [ENTRY_BITS-1:0] ram_rdata;

  logic                  rd_valid;
  logic [INDEX_BITS-1:0] rd_row;
  logic [INDEX_BITS-1:0] rd_col;
  logic [VALUE_BITS-1:0] rd_value;

  logic                  is_access;
  logic                  oob;
  logic                  skip;
  logic                  issue;
  logic                  value_is_default;
  logic                  hit_take;
  logic                  free_take;
  logic                  grow;
  logic [VALUE_BITS-1:0] result_value;
  status_t               result_status;

  smsu_ram #(
    .WIDTH (ENTRY_BITS),
    .DEPTH (SLOT_COUNT)
  ) u_slot_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (issue),
    .raddr (issue_idx[ADDR_BITS-1:0]),
    .rdata (ram_rdata)
  );

  assign rd_valid = ram_rdata[ENTRY_BITS-1];
  assign rd_row   = ram_rdata[ENTRY_BITS-2 -: INDEX_BITS];
  assign rd_col   = ram_rdata[VALUE_BITS+INDEX_BITS-1 -: INDEX_BITS];
  assign rd_value = ram_rdata[VALUE_BITS-1:0];

  assign is_access        = (cmd_q == CMD_GET) || (cmd_q == CMD_SET);
  assign oob              = ({1'b0, row_q} >= row_count) || ({1'b0, col_q} >= col_count);
  assign skip             = !is_access || oob;
  assign issue            = cmd.scan && !skip && (issue_idx != hwm);
  assign value_is_default = (value_q == default_value);

  assign hit_take  = pend && !hit && rd_valid && (rd_row == row_q) && (rd_col == col_q);
  assign free_take = pend && !free_found && !rd_valid;

  assign stat.scan_done = skip || ((issue_idx == hwm) && !pend);
  assign stat.out_free  = !rsp_valid || rsp_ready;

  always_comb begin
    ram_we        = 1'b0;
    ram_waddr     = hit_addr;
    ram_wdata     = {1'b1, row_q, col_q, value_q};
    grow          = 1'b0;
    result_value  = '0;
    result_status = ST_OK;
    if (is_access) begin
      priority if (oob) begin
        result_status = ST_OOB;
      end else if (cmd_q == CMD_GET) begin
        result_value = hit ? hit_value : default_value;
      end else if (hit) begin
        ram_we = cmd.finish;
        if (value_is_default) begin
          ram_wdata = {1'b0, row_q, col_q, value_q};
        end
      end else if (value_is_default) begin
        ram_we = 1'b0;
      end else if (free_found) begin
        ram_we    = cmd.finish;
        ram_waddr = free_addr;
      end else if (hwm != SLOT_LIMIT) begin
        ram_we    = cmd.finish;
        ram_waddr = hwm[ADDR_BITS-1:0];
        grow      = 1'b1;
      end else begin
        result_status = ST_FULL;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_count     <= SIZE_RESET;
      col_count     <= SIZE_RESET;
      default_value <= '0;
      hwm           <= '0;
      issue_idx     <= '0;
      pend          <= 1'b0;
      hit           <= 1'b0;
      free_found    <= 1'b0;
      rsp_valid     <= 1'b0;
    end else begin
      if (cfg_write) begin
        unique case (cfg_index)
          REG_ROW_COUNT:     row_count     <= cfg_data[COUNT_BITS-1:0];
          REG_COL_COUNT:     col_count     <= cfg_data[COUNT_BITS-1:0];
          REG_DEFAULT_VALUE: default_value <= cfg_data[VALUE_BITS-1:0];
          default: begin
          end
        endcase
      end
      if (cmd.load) begin
        issue_idx  <= '0;
        pend       <= 1'b0;
        hit        <= 1'b0;
        free_found <= 1'b0;
      end else begin
        if (issue) begin
          issue_idx <= issue_idx + CNT_BITS'(1);
        end
        pend <= issue;
        if (hit_take) begin
          hit <= 1'b1;
        end
        if (free_take) begin
          free_found <= 1'b1;
        end
      end
      if (cmd.finish) begin
        rsp_valid <= 1'b1;
        if (cmd_q == CMD_CLEAR) begin
          hwm <= '0;
        end else if (grow) begin
          hwm <= hwm + CNT_BITS'(1);
        end
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_q   <= req_command;
      row_q   <= req_row;
      col_q   <= req_col;
      value_q <= req_value;
    end
    if (issue) begin
      pend_addr <= issue_idx[ADDR_BITS-1:0];
    end
    if (hit_take) begin
      hit_addr  <= pend_addr;
      hit_value <= rd_value;
    end
    if (free_take) begin
      free_addr <= pend_addr;
    end
    if (cmd.finish) begin
      rsp_read_value <= result_value;
      rsp_status     <= result_status;
    end
  end

endmodule

>>> rtl/sparse_matrix_store_unit.sv
// ----------------------------------------------------------------------------
// Sparse matrix store unit
// Keeps non-default matrix elements as (row, col, value) entries in a slot RAM.
// Channels: req carries get, set or clear commands; rsp returns one read_value
// and status per command; cfg writes row_count, col_count and default_value
// and is always ready.
// A get or set reads the slots one per RAM cycle up to the fill mark h (one
// above the highest slot filled since the last clear), then writes back at
// most one entry; an index out of bounds skips the scan. A clear resets the
// fill mark. One command is in flight at a time; req is ready again in the
// cycle in which the result first shows on rsp.
// Reset restores the config registers, empties the store and needs no RAM
// sweep. The result register holds while rsp is stalled; req stays ready for
// one more command, which then waits at write-back until rsp drains.
// ----------------------------------------------------------------------------
`include "sparse_matrix_store_unit_defines.svh"

module sparse_matrix_store_unit import smsu_pkg::*; #(
  parameter int unsigned SLOT_COUNT = 256,
  parameter int unsigned INDEX_BITS = 16,
  parameter int unsigned VALUE_BITS = 32
) (
  input  logic        clk,
  input  logic        rst,
  smsu_cfg_if.sink    cfg,
  smsu_req_if.sink    req,
  smsu_rsp_if.source  rsp
);

  localparam int unsigned CFG_BITS =
    (VALUE_BITS > INDEX_BITS + 1) ? VALUE_BITS : INDEX_BITS + 1;

  smsu_cmd_t  cmd;
  smsu_stat_t stat;

  assign cfg.ready = 1'b1;

  smsu_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  smsu_datapath #(
    .SLOT_COUNT (SLOT_COUNT),
    .INDEX_BITS (INDEX_BITS),
    .VALUE_BITS (VALUE_BITS),
    .CFG_BITS   (CFG_BITS)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .stat           (stat),
    .cfg_write      (cfg.valid && cfg.ready),
    .cfg_index      (cfg.index),
    .cfg_data       (cfg.data),
    .req_command    (req.command),
    .req_row        (req.row),
    .req_col        (req.col),
    .req_value      (req.value),
    .rsp_ready      (rsp.ready),
    .rsp_valid      (rsp.valid),
    .rsp_read_value (rsp.read_value),
    .rsp_status     (rsp.status)
  );

  `SMSU_ASSERT_NEXT(busy_after_transfer, clk, rst, req.valid && req.ready, !req.ready)
  `SMSU_ASSERT_SAME(no_result_overwrite, clk, rst, cmd.finish, stat.out_free)
  `SMSU_ASSERT_NEXT(result_after_finish, clk, rst, cmd.finish, rsp.valid && req.ready)

endmodule

>>> test/smsu_checker.sv
// ----------------------------------------------------------------------------
// Sparse matrix store unit checker
// Watches the configuration, request and response channels. Keeps its own
// copy of the slot pool and registers, predicts one answer per accepted
// command and compares every returned answer, field by field, in order.
// ----------------------------------------------------------------------------
module smsu_checker import smsu_pkg::*; #(
  parameter int unsigned SLOTS = 256
) (
  input  logic        clk,
  input  logic        rst,
  smsu_cfg_if         cfg,
  smsu_req_if         req,
  smsu_rsp_if         rsp,
  output int unsigned checked_count,
  output int unsigned fail_count
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [31:0] read_value;
    status_t     status;
  } answer_t;

  answer_t          answer_q[$];
  logic [SLOTS-1:0] slot_used;
  logic [15:0]      slot_row [SLOTS];
  logic [15:0]      slot_col [SLOTS];
  logic [31:0]      slot_val [SLOTS];
  logic [16:0]      rows_in_use;
  logic [16:0]      cols_in_use;
  logic [31:0]      absent_value;
  int unsigned      mismatches;

  assign fail_count = mismatches;

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    if (mismatches < 200) begin
      $display("[%0t] %s: got %h, expected %h", $time, what, got, want);
    end
    mismatches++;
  endtask

  function automatic answer_t apply_command(input cmd_code_t cmd, input logic [15:0] r,
                                            input logic [15:0] c, input logic [31:0] x);
    answer_t ans;
    int      hit;
    int      free_slot;
    int      i;
    ans.read_value = '0;
    ans.status     = ST_OK;
    hit            = -1;
    free_slot      = -1;
    if (cmd == CMD_CLEAR) begin
      slot_used = '0;
    end else if (cmd == CMD_GET || cmd == CMD_SET) begin
      if ({1'b0, r} >= rows_in_use || {1'b0, c} >= cols_in_use) begin
        ans.status = ST_OOB;
      end else begin
        for (i = 0; i < SLOTS; i++) begin
          if (hit < 0 && slot_used[i] && slot_row[i] == r && slot_col[i] == c) hit = i;
          if (free_slot < 0 && !slot_used[i]) free_slot = i;
        end
        if (cmd == CMD_GET) begin
          ans.read_value = (hit >= 0) ? slot_val[hit] : absent_value;
        end else if (hit >= 0) begin
          if (x == absent_value) slot_used[hit] = 1'b0;
          else slot_val[hit] = x;
        end else if (x != absent_value) begin
          if (free_slot < 0) begin
            ans.status = ST_FULL;
          end else begin
            slot_used[free_slot] = 1'b1;
            slot_row[free_slot]  = r;
            slot_col[free_slot]  = c;
            slot_val[free_slot]  = x;
          end
        end
      end
    end
    return ans;
  endfunction

  always @(posedge clk) begin : monitor
    answer_t want;
    if (rst) begin
      slot_used     = '0;
      rows_in_use   = 17'd65536;
      cols_in_use   = 17'd65536;
      absent_value  = '0;
      mismatches    = 0;
      answer_q.delete();
      checked_count <= 0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          REG_ROW_COUNT:     rows_in_use  = cfg.data[16:0];
          REG_COL_COUNT:     cols_in_use  = cfg.data[16:0];
          REG_DEFAULT_VALUE: absent_value = cfg.data[31:0];
          default: ;
        endcase
      end
      if (rsp.valid && rsp.ready) begin
        if (answer_q.size() == 0) begin
          report("result with no command pending, read_value", rsp.read_value, '0);
        end else begin
          want = answer_q.pop_front();
          if (rsp.read_value !== want.read_value) begin
            report("read_value", rsp.read_value, want.read_value);
          end
          if (rsp.status !== want.status) begin
            report("status", {30'b0, rsp.status}, {30'b0, want.status});
          end
        end
        checked_count <= checked_count + 1;
      end
      if (req.valid && req.ready) begin
        answer_q.insert(answer_q.size(),
                        apply_command(req.command, req.row, req.col, req.value));
      end
    end
  end

endmodule

>>> test/testbench.sv
// ----------------------------------------------------------------------------
// Sparse matrix store unit testbench
// Drives directed and random get, set and clear commands through the request
// channel in bursts, stalls the response channel, reprograms matrix size and
// default value between phases (zero size, single cell, full range, pool
// full) and lets the checker score every answer.
// ----------------------------------------------------------------------------
module testbench;
  import smsu_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam cmd_code_t CMD_UNUSED  = 2'd3;
  localparam int        STALL_LIMIT = 4000;
  localparam int        HOT_CELLS   = 8;

  logic        clk;
  logic        rst;
  int unsigned checked_count;
  int unsigned fail_count;
  int unsigned issued;
  int unsigned get_count;
  int unsigned set_count;
  int unsigned clear_count;
  int unsigned phase_count;
  int          burst_left;
  int          idle_cycles;
  logic [31:0] cur_default;
  logic [15:0] hot_row [HOT_CELLS];
  logic [15:0] hot_col [HOT_CELLS];

  smsu_cfg_if cfg ();
  smsu_req_if req ();
  smsu_rsp_if rsp ();

  sparse_matrix_store_unit uut (
    .clk (clk),
    .rst (rst),
    .cfg (cfg),
    .req (req),
    .rsp (rsp)
  );

  smsu_checker checker_i (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .req           (req),
    .rsp           (rsp),
    .checked_count (checked_count),
    .fail_count    (fail_count)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst || (req.valid && req.ready) || (rsp.valid && rsp.ready) || (cfg.valid && cfg.ready))
    begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("Timeout: no transfer for %0d cycles", STALL_LIMIT);
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin : receiver
    int stall_left;
    int mode_left;
    int mode;
    stall_left = 0;
    mode_left  = 0;
    mode       = 0;
    rsp.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (mode_left == 0) begin
        mode      = $urandom_range(0, 2);
        mode_left = $urandom_range(50, 400);
      end
      mode_left--;
      if (stall_left > 0) begin
        stall_left--;
        rsp.ready <= 1'b0;
      end else begin
        rsp.ready <= 1'b1;
        case (mode)
          1: if ($urandom_range(0, 2) == 0) stall_left = $urandom_range(1, 3);
          2: if ($urandom_range(0, 7) == 0) stall_left = $urandom_range(4, 24);
          default: ;
        endcase
      end
    end
  end

  task automatic send(input cmd_code_t cmd, input logic [15:0] r, input logic [15:0] c,
                      input logic [31:0] v);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 16);
      if (gap > 0) begin
        req.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
    end
    burst_left--;
    req.valid   <= 1'b1;
    req.command <= cmd;
    req.row     <= r;
    req.col     <= c;
    req.value   <= v;
    do @(posedge clk); while (!req.ready);
    issued++;
    case (cmd)
      CMD_GET:   get_count++;
      CMD_SET:   set_count++;
      CMD_CLEAR: clear_count++;
      default: ;
    endcase
  endtask

  task automatic configure(input logic [16:0] rows, input logic [16:0] cols,
                           input logic [31:0] dflt);
    cfg_index_t  reg_index [3];
    logic [31:0] reg_data [3];
    int          i;
    req.valid <= 1'b0;
    while (issued != checked_count) @(posedge clk);
    repeat (2) @(posedge clk);
    reg_index[0] = REG_ROW_COUNT;
    reg_index[1] = REG_COL_COUNT;
    reg_index[2] = REG_DEFAULT_VALUE;
    reg_data[0]  = {15'b0, rows};
    reg_data[1]  = {15'b0, cols};
    reg_data[2]  = dflt;
    for (i = 0; i < 3; i++) begin
      cfg.valid <= 1'b1;
      cfg.index <= reg_index[i];
      cfg.data  <= reg_data[i];
      do @(posedge clk); while (!cfg.ready);
    end
    cfg.valid <= 1'b0;
    cur_default = dflt;
    burst_left  = 0;
    phase_count++;
  endtask

  function automatic logic [31:0] fresh_value();
    logic [31:0] v;
    do v = $urandom; while (v == cur_default);
    return v;
  endfunction

  function automatic logic [31:0] pick_default();
    case ($urandom_range(0, 2))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  task automatic random_phase(input int count, input int row_hi, input int col_hi);
    int          n;
    int          pick;
    int          k;
    cmd_code_t   cmd;
    logic [15:0] r;
    logic [15:0] c;
    logic [31:0] v;
    for (k = 0; k < HOT_CELLS; k++) begin
      hot_row[k] = 16'($urandom_range(0, row_hi));
      hot_col[k] = 16'($urandom_range(0, col_hi));
    end
    for (n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 3) cmd = CMD_CLEAR;
      else if (pick < 5) cmd = CMD_UNUSED;
      else if (pick < 50) cmd = CMD_GET;
      else cmd = CMD_SET;
      if ($urandom_range(0, 1) == 0) begin
        k = $urandom_range(0, HOT_CELLS - 1);
        r = hot_row[k];
        c = hot_col[k];
      end else begin
        r = 16'($urandom_range(0, row_hi));
        c = 16'($urandom_range(0, col_hi));
      end
      v = ($urandom_range(0, 3) == 0) ? cur_default : fresh_value();
      send(cmd, r, c, v);
    end
  endtask

  task automatic fill_pool();
    int i;
    configure(17'd17, 17'd16, pick_default());
    send(CMD_CLEAR, 16'($urandom), 16'($urandom), $urandom);
    for (i = 0; i < 264; i++) begin
      send(CMD_SET, 16'(i / 16), 16'(i % 16), fresh_value());
    end
    random_phase(20, 17, 16);
  endtask

  initial begin
    int b;
    issued      = 0;
    get_count   = 0;
    set_count   = 0;
    clear_count = 0;
    phase_count = 0;
    burst_left  = 0;
    cur_default = '0;
    rst         <= 1'b1;
    req.valid   <= 1'b0;
    req.command <= CMD_GET;
    req.row     <= '0;
    req.col     <= '0;
    req.value   <= '0;
    cfg.valid   <= 1'b0;
    cfg.index   <= REG_ROW_COUNT;
    cfg.data    <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send(CMD_GET,    16'h0000, 16'h0000, 32'h0000_0000);
    send(CMD_SET,    16'h0000, 16'h0000, 32'hFFFF_FFFF);
    send(CMD_GET,    16'h0000, 16'h0000, 32'hFFFF_FFFF);
    send(CMD_SET,    16'hFFFF, 16'hFFFF, 32'h0000_0001);
    send(CMD_GET,    16'hFFFF, 16'hFFFF, 32'h0000_0000);
    send(CMD_SET,    16'hFFFF, 16'h0000, 32'h0000_0000);
    send(CMD_GET,    16'hFFFF, 16'h0000, 32'h0000_0000);
    send(CMD_SET,    16'h0000, 16'h0000, 32'h1234_5678);
    send(CMD_SET,    16'h0000, 16'h0000, 32'h0000_0000);
    send(CMD_GET,    16'h0000, 16'h0000, 32'h0000_0000);
    send(CMD_UNUSED, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
    send(CMD_CLEAR,  16'h1234, 16'h5678, $urandom);
    send(CMD_GET,    16'hFFFF, 16'hFFFF, 32'h0000_0000);

    configure(17'd1, 17'd1, 32'hFFFF_FFFF);
    send(CMD_GET, 16'h0000, 16'h0000, 32'h0000_0000);
    send(CMD_GET, 16'h0001, 16'h0000, 32'h0000_0000);
    send(CMD_GET, 16'h0000, 16'h0001, 32'h0000_0000);
    send(CMD_SET, 16'h0000, 16'h0001, 32'h0000_0005);
    send(CMD_SET, 16'h0000, 16'h0000, 32'h0000_0000);

    configure(17'd1, 17'd1, 32'h0000_0000);
    send(CMD_GET, 16'h0000, 16'h0000, 32'h0000_0000);
    send(CMD_SET, 16'h0000, 16'h0000, 32'h0000_0000);

    configure(17'd1, 17'd1, 32'h0000_0007);
    send(CMD_GET, 16'h0000, 16'h0000, 32'h0000_0000);

    configure(17'd0, 17'd65536, 32'h0000_0000);
    send(CMD_GET, 16'h0000, 16'h0000, 32'h0000_0000);
    send(CMD_SET, 16'h0000, 16'h0000, 32'h0000_0009);

    configure(17'd65536, 17'd65536, $urandom);
    random_phase(50, 65535, 65535);
    for (b = 0; b < 3; b++) begin
      configure(17'($urandom_range(1, 12)), 17'($urandom_range(1, 12)), pick_default());
      random_phase(45, 15, 15);
    end
    fill_pool();
    configure(17'h1FFFF, 17'd1, 32'hFFFF_FFFF);
    random_phase(15, 65535, 3);
    configure(17'd1, 17'd65536, 32'h0000_0000);
    random_phase(15, 3, 65535);
    configure(17'd65536, 17'h1FFFF, pick_default());
    random_phase(50, 65535, 65535);

    req.valid <= 1'b0;
    while (issued != checked_count) @(posedge clk);
    repeat (300) @(posedge clk);
    $display("Covered %0d commands (%0d get, %0d set, %0d clear) over %0d register settings",
             issued, get_count, set_count, clear_count, phase_count);
    $display("Answers compared: %0d, mismatches: %0d", checked_count, fail_count);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
